// ===== hdl/drfp_pkg.sv =====
// ----------------------------------------------------------------------------
// DHCP reply frame parser package
// Status codes, register indexes and the fixed frame offsets that the
// parser checks.
// ----------------------------------------------------------------------------
package drfp_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_IPV4 = 3'd1,
        ST_NOT_UDP  = 3'd2,
        ST_PORTS    = 3'd3,
        ST_OP_XID   = 3'd4,
        ST_SHORT    = 3'd5,
        ST_NO_TYPE  = 3'd6,
        ST_NO_MASK  = 3'd7
    } t_status;

    typedef enum logic {
        CFG_EXPECTED_XID = 1'b0,
        CFG_EXPECT_ACK   = 1'b1
    } t_cfg_index;

    localparam int CFG_DATA_W = 32;

    // Byte offsets, taken at the last byte of each field.
    localparam int OFS_ETHERTYPE = 13;
    localparam int OFS_PROTOCOL  = 23;
    localparam int OFS_SRC_PORT  = 35;
    localparam int OFS_DST_PORT  = 37;
    localparam int OFS_OP        = 42;
    localparam int OFS_XID       = 49;
    localparam int OFS_YIADDR    = 61;
    localparam int OFS_SIADDR    = 65;
    localparam int OPT_START     = 282;
    localparam int MIN_FRAME     = 283;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] PORT_SERVER    = 16'd67;
    localparam logic [15:0] PORT_CLIENT    = 16'd68;
    localparam logic [7:0]  OP_REPLY       = 8'd2;
    localparam logic [7:0]  OPT_PAD        = 8'h00;
    localparam logic [7:0]  OPT_END        = 8'hff;
    localparam logic [7:0]  OPT_MASK       = 8'h01;
    localparam logic [7:0]  OPT_MSG_TYPE   = 8'd53;
    localparam logic [7:0]  MSG_OFFER      = 8'd2;
    localparam logic [7:0]  MSG_ACK        = 8'd5;
    localparam logic [7:0]  LEN_MSG_TYPE   = 8'd1;
    localparam logic [7:0]  LEN_MASK       = 8'd4;

endpackage

// ===== hdl/drfp_in_if.sv =====
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel that carries one frame byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface drfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// ===== hdl/drfp_out_if.sv =====
// ----------------------------------------------------------------------------
// Parse result channel
// Valid/ready channel that carries the status and captured addresses of a frame.
// ----------------------------------------------------------------------------
interface drfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] offered_address;
    logic [31:0] server_address;
    logic [31:0] subnet_mask;

    modport source (output valid, output status, output offered_address,
                    output server_address, output subnet_mask, input ready);
    modport sink   (input valid, input status, input offered_address,
                    input server_address, input subnet_mask, output ready);
endinterface

// ===== hdl/dhcp_reply_frame_parser_unit.sv =====
// The result word of a frame is registered into the output buffer when its last byte is accepted.
// One byte per cycle while the input is ready; the per-byte checks and the option walk are one register stage.
// A two-word output buffer lets bytes flow while one result waits; input stalls only when
// both buffer words are occupied.
// Reset (synchronous, active low) clears the frame state, the output buffer valid flags and both
// configuration registers.
// ----------------------------------------------------------------------------
// DHCP reply frame parser
// Checks an Ethernet frame byte by byte as a DHCP offer or ack, captures the
// offered and server addresses and the subnet mask, and reports a status word.
// ----------------------------------------------------------------------------
module dhcp_reply_frame_parser_unit #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  drfp_pkg::t_cfg_index           i_cfg_index,
    input  logic [drfp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    drfp_in_if.sink                        i_frame,
    drfp_out_if.source                     o_result
);
    import drfp_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int NOS_W = $clog2(MAX_FRAME_BYTES + 260);

    typedef struct packed {
        t_status     status;
        logic [31:0] yiaddr;
        logic [31:0] siaddr;
        logic [31:0] mask;
    } t_result;

    // Configuration
    logic [31:0] r_expected_xid;
    logic        r_expect_ack;

    // Frame state
    logic [POS_W-1:0] r_pos,       n_pos;
    t_status          r_fail,      n_fail;
    logic [31:0]      r_ws,        n_ws;
    logic [31:0]      r_yiaddr,    n_yiaddr;
    logic [31:0]      r_siaddr,    n_siaddr;
    logic [31:0]      r_mask,      n_mask;
    logic [NOS_W-1:0] r_nos,       n_nos;
    logic [7:0]       r_code,      n_code;
    logic [7:0]       r_len,       n_len;
    logic             r_ended,     n_ended;
    logic             r_matched,   n_matched;

    // Output buffer
    t_result r_out,  r_skid;
    logic    r_out_valid, r_skid_valid;

    logic             accept;
    logic             push;
    logic             pop;
    logic [7:0]       b;
    logic [NOS_W-1:0] pe;
    t_result          res;
    t_status          fin_status;

    assign b      = i_frame.frame_byte;
    assign accept = i_frame.valid && i_frame.ready;
    assign push   = accept && i_frame.frame_last;
    assign pop    = r_out_valid && o_result.ready;
    assign pe     = NOS_W'(r_pos);

    assign i_frame.ready = !r_skid_valid;

    always_comb begin
        n_pos     = r_pos;
        n_fail    = r_fail;
        n_ws      = r_ws;
        n_yiaddr  = r_yiaddr;
        n_siaddr  = r_siaddr;
        n_mask    = r_mask;
        n_nos     = r_nos;
        n_code    = r_code;
        n_len     = r_len;
        n_ended   = r_ended;
        n_matched = r_matched;

        if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            n_ws  = {r_ws[23:0], b};

            // Header checks; only the first failure is kept.
            if (r_fail == ST_OK) begin
                if (r_pos == POS_W'(OFS_ETHERTYPE) && n_ws[15:0] != ETHERTYPE_IPV4) begin
                    n_fail = ST_NOT_IPV4;
                end else if (r_pos == POS_W'(OFS_PROTOCOL) && b != PROTO_UDP) begin
                    n_fail = ST_NOT_UDP;
                end else if (r_pos == POS_W'(OFS_SRC_PORT) && n_ws[15:0] != PORT_SERVER) begin
                    n_fail = ST_PORTS;
                end else if (r_pos == POS_W'(OFS_DST_PORT) && n_ws[15:0] != PORT_CLIENT) begin
                    n_fail = ST_PORTS;
                end else if (r_pos == POS_W'(OFS_OP) && b != OP_REPLY) begin
                    n_fail = ST_OP_XID;
                end else if (r_pos == POS_W'(OFS_XID) && n_ws != r_expected_xid) begin
                    n_fail = ST_OP_XID;
                end
            end
            if (r_pos == POS_W'(OFS_YIADDR)) begin
                n_yiaddr = n_ws;
            end
            if (r_pos == POS_W'(OFS_SIADDR)) begin
                n_siaddr = n_ws;
            end

            // Option walk: code byte, length byte, then data up to the next start.
            if (!r_ended && pe >= NOS_W'(OPT_START)) begin
                if (pe == r_nos) begin
                    if (b == OPT_END) begin
                        n_ended = 1'b1;
                    end else if (b == OPT_PAD) begin
                        n_nos = pe + NOS_W'(1);
                    end else begin
                        n_code = b;
                    end
                end else if (pe == r_nos + NOS_W'(1)) begin
                    n_len = b;
                    n_nos = pe + NOS_W'(b) + NOS_W'(1);
                end else if (pe < r_nos) begin
                    // The data byte index equals the option length at its final byte.
                    if (pe + NOS_W'(r_len) == r_nos && r_code == OPT_MSG_TYPE
                            && r_len == LEN_MSG_TYPE
                            && b == (r_expect_ack ? MSG_ACK : MSG_OFFER)) begin
                        n_matched = 1'b1;
                    end
                    if (pe + NOS_W'(r_len) == r_nos + NOS_W'(3) && r_code == OPT_MASK
                            && r_len == LEN_MASK) begin
                        n_mask = n_ws;
                    end
                end
            end
        end

        if (n_fail != ST_OK) begin
            fin_status = n_fail;
        end else if (n_pos < POS_W'(MIN_FRAME)) begin
            fin_status = ST_SHORT;
        end else if (!n_matched) begin
            fin_status = ST_NO_TYPE;
        end else if (r_expect_ack && n_mask == 32'd0) begin
            fin_status = ST_NO_MASK;
        end else begin
            fin_status = ST_OK;
        end

        res.status = fin_status;
        res.yiaddr = (fin_status == ST_OK) ? n_yiaddr : 32'd0;
        res.siaddr = (fin_status == ST_OK) ? n_siaddr : 32'd0;
        res.mask   = (fin_status == ST_OK) ? n_mask   : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_xid <= '0;
            r_expect_ack   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_XID: r_expected_xid <= i_cfg_data;
                CFG_EXPECT_ACK:   r_expect_ack   <= i_cfg_data[0];
                default:          r_expect_ack   <= r_expect_ack;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || push) begin
            r_pos     <= '0;
            r_fail    <= ST_OK;
            r_ws      <= '0;
            r_yiaddr  <= '0;
            r_siaddr  <= '0;
            r_mask    <= '0;
            r_nos     <= NOS_W'(OPT_START);
            r_code    <= '0;
            r_len     <= '0;
            r_ended   <= 1'b0;
            r_matched <= 1'b0;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_fail    <= n_fail;
            r_ws      <= n_ws;
            r_yiaddr  <= n_yiaddr;
            r_siaddr  <= n_siaddr;
            r_mask    <= n_mask;
            r_nos     <= n_nos;
            r_code    <= n_code;
            r_len     <= n_len;
            r_ended   <= n_ended;
            r_matched <= n_matched;
        end
    end

    // Two-word output buffer: the skid word only fills while the front word waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= push;
                if (push) begin
                    r_skid <= res;
                end
            end else begin
                r_out_valid <= push;
                if (push) begin
                    r_out <= res;
                end
            end
        end else if (push) begin
            if (r_out_valid) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.status          = r_out.status;
    assign o_result.offered_address = r_out.yiaddr;
    assign o_result.server_address  = r_out.siaddr;
    assign o_result.subnet_mask     = r_out.mask;

endmodule
